// ===== hdl/one_shot_timer_table_macros.svh =====
// ----------------------------------------------------------------------------
// one_shot_timer_table assertion macros
// shared concurrent assertion forms for the timer table
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_TABLE_MACROS_SVH
`define ONE_SHOT_TIMER_TABLE_MACROS_SVH

// same-cycle implication
`define OSTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OSTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ostt_pkg.sv =====
// ----------------------------------------------------------------------------
// ostt_pkg
// types and constants of the one-shot timer table
// ----------------------------------------------------------------------------
`default_nettype none

package ostt_pkg;

  typedef enum logic [1:0] {
    KIND_ADDED   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SUM,
    S_WRITE,
    S_RD,
    S_SUB,
    S_CHK,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  // reciprocal of 10 for a 32-bit dividend, exact with a shift of 35
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [3:0]  MAX_OUT     = 4'd8;

endpackage

`default_nettype wire

// ===== hdl/ostt_in_if.sv =====
// ----------------------------------------------------------------------------
// ostt_in_if
// request channel: add or poll transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface ostt_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] now;
  logic [31:0] delay_usec;
  logic [7:0]  handle;

  modport source (output valid, action, now, delay_usec, handle, input ready);
  modport sink   (input valid, action, now, delay_usec, handle, output ready);
endinterface

`default_nettype wire

// ===== hdl/ostt_out_if.sv =====
// ----------------------------------------------------------------------------
// ostt_out_if
// result channel: one transaction per reported event
// ----------------------------------------------------------------------------
`default_nettype none

interface ostt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] fired_handle;
  logic [2:0] slot;
  logic       last;

  modport source (output valid, kind, fired_handle, slot, last, input ready);
  modport sink   (input valid, kind, fired_handle, slot, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/ostt_alu.sv =====
// ----------------------------------------------------------------------------
// ostt_alu
// shared registered unit: divide by ten via reciprocal, add, subtract
// ----------------------------------------------------------------------------
`default_nettype none

module ostt_alu (
  input  wire logic              clk,
  input  wire ostt_pkg::alu_req_t req,
  output logic [31:0]            res
);

  logic [63:0] prod;
  logic [31:0] res_r;
  logic [31:0] res_nxt;

  always_comb begin
    prod    = {32'd0, req.a} * {32'd0, ostt_pkg::RECIP10};
    res_nxt = res_r;
    case (req.op)
      ostt_pkg::OP_MUL: res_nxt = 32'(prod >> ostt_pkg::RECIP_SHIFT);
      ostt_pkg::OP_ADD: res_nxt = req.a + req.b;
      ostt_pkg::OP_SUB: res_nxt = req.a - req.b;
      default:          res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== hdl/ostt_slot_mem.sv =====
// ----------------------------------------------------------------------------
// ostt_slot_mem
// deadline and handle storage, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ostt_slot_mem #(
  parameter int SLOTS = 8,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire logic [31:0]      wdeadline,
  input  wire logic [7:0]       whandle,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output logic [31:0]           rdeadline,
  output logic [7:0]            rhandle
);

  logic [39:0] mem [SLOTS];
  logic [39:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wdeadline, whandle};
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdeadline = rdata_r[39:8];
  assign rhandle   = rdata_r[7:0];

endmodule

`default_nettype wire

// ===== hdl/one_shot_timer_table.sv =====
// ----------------------------------------------------------------------------
// one_shot_timer_table
// table of one-shot timers with add and poll transactions
// ----------------------------------------------------------------------------
// An add transaction, once accepted, divides the delay by ten in the
// shared unit, adds it to now for the deadline and writes the slot. It
// stores the timer in the lowest free slot, or reports table full. A poll
// transaction walks the slots in order (registered read of the slot
// memory, subtract in the shared unit, check for each slot) and then gives
// its final result. Both kinds may wait on out_ch.ready, and a poll also
// stalls its walk while an earlier expiry waits on out_ch.ready. A poll
// reports each expired timer, at most MAX_OUT of them, and frees its slot,
// marks the final result with last, and reports none when nothing expired.
// in_ch.ready is high only between transactions. Slot storage needs no
// clearing after reset: free slots are read too, but only busy ones fire.
`default_nettype none

`include "one_shot_timer_table_macros.svh"

module one_shot_timer_table #(
  parameter int SLOTS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ostt_in_if.sink     in_ch,
  ostt_out_if.source  out_ch
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ostt_pkg::state_t   state_r, state_nxt;
  ostt_pkg::alu_req_t alu_req;
  logic [31:0]        alu_res;

  logic               act_r, act_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [31:0]        delay_r, delay_nxt;
  logic [7:0]         hdl_r, hdl_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [7:0]         pend_hdl_r, pend_hdl_nxt;
  logic [IDX_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [SLOTS-1:0]   busy_r, busy_nxt;

  logic               out_valid_r, out_valid_nxt;
  ostt_pkg::kind_t    out_kind_r, out_kind_nxt;
  logic [7:0]         out_hdl_r, out_hdl_nxt;
  logic [2:0]         out_slot_r, out_slot_nxt;
  logic               out_last_r, out_last_nxt;

  logic               mem_we;
  logic               mem_re;
  logic [31:0]        rd_deadline;
  logic [7:0]         rd_handle;

  logic               out_free;
  logic               fire;
  logic               idx_last;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  ostt_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .res (alu_res)
  );

  ostt_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk       (clk),
    .we        (mem_we),
    .waddr     (free_idx),
    .wdeadline (alu_res),
    .whandle   (hdl_r),
    .re        (mem_re),
    .raddr     (idx_r),
    .rdeadline (rd_deadline),
    .rhandle   (rd_handle)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign idx_last = (idx_r == IDX_W'(SLOTS - 1));
  assign fire     = busy_r[idx_r] && (alu_res != 32'd0) && !alu_res[31] &&
                    (cnt_r < ostt_pkg::MAX_OUT);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ostt_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ch.action ? ostt_pkg::S_RD : ostt_pkg::S_DIV;
        end
      end
      ostt_pkg::S_DIV:   state_nxt = ostt_pkg::S_SUM;
      ostt_pkg::S_SUM:   state_nxt = ostt_pkg::S_WRITE;
      ostt_pkg::S_WRITE: begin
        if (out_free) begin
          state_nxt = ostt_pkg::S_IDLE;
        end
      end
      ostt_pkg::S_RD:    state_nxt = ostt_pkg::S_SUB;
      ostt_pkg::S_SUB:   state_nxt = ostt_pkg::S_CHK;
      ostt_pkg::S_CHK: begin
        if (!(fire && pend_v_r && !out_free)) begin
          state_nxt = idx_last ? ostt_pkg::S_FIN : ostt_pkg::S_RD;
        end
      end
      ostt_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = ostt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ostt_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    act_nxt       = act_r;
    now_nxt       = now_r;
    delay_nxt     = delay_r;
    hdl_nxt       = hdl_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_hdl_nxt  = pend_hdl_r;
    pend_slot_nxt = pend_slot_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_hdl_nxt   = out_hdl_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    in_ch.ready   = 1'b0;
    // hold the shared unit result by default
    alu_req.op    = ostt_pkg::OP_ADD;
    alu_req.a     = alu_res;
    alu_req.b     = 32'd0;

    case (state_r)
      ostt_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          act_nxt    = in_ch.action;
          now_nxt    = in_ch.now;
          delay_nxt  = in_ch.delay_usec;
          hdl_nxt    = in_ch.handle;
          idx_nxt    = '0;
          cnt_nxt    = 4'd0;
          pend_v_nxt = 1'b0;
        end
      end
      ostt_pkg::S_DIV: begin
        alu_req.op = ostt_pkg::OP_MUL;
        alu_req.a  = delay_r;
      end
      ostt_pkg::S_SUM: begin
        alu_req.op = ostt_pkg::OP_ADD;
        alu_req.a  = now_r;
        alu_req.b  = alu_res;
      end
      ostt_pkg::S_WRITE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_hdl_nxt   = 8'd0;
          if (free_found) begin
            out_kind_nxt       = ostt_pkg::KIND_ADDED;
            out_slot_nxt       = 3'(free_idx);
            mem_we             = 1'b1;
            busy_nxt[free_idx] = 1'b1;
          end else begin
            out_kind_nxt = ostt_pkg::KIND_FULL;
            out_slot_nxt = 3'd0;
          end
        end
      end
      ostt_pkg::S_RD: begin
        mem_re = 1'b1;
      end
      ostt_pkg::S_SUB: begin
        alu_req.op = ostt_pkg::OP_SUB;
        alu_req.a  = now_r;
        alu_req.b  = rd_deadline;
      end
      ostt_pkg::S_CHK: begin
        if (!(fire && pend_v_r && !out_free)) begin
          if (fire) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = ostt_pkg::KIND_EXPIRED;
              out_hdl_nxt   = pend_hdl_r;
              out_slot_nxt  = 3'(pend_slot_r);
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt      = 1'b1;
            pend_hdl_nxt    = rd_handle;
            pend_slot_nxt   = idx_r;
            busy_nxt[idx_r] = 1'b0;
            cnt_nxt         = cnt_r + 4'd1;
          end
          if (!idx_last) begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ostt_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          if (pend_v_r) begin
            out_kind_nxt = ostt_pkg::KIND_EXPIRED;
            out_hdl_nxt  = pend_hdl_r;
            out_slot_nxt = 3'(pend_slot_r);
          end else begin
            out_kind_nxt = ostt_pkg::KIND_NONE;
            out_hdl_nxt  = 8'd0;
            out_slot_nxt = 3'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ostt_pkg::S_IDLE;
      idx_r       <= '0;
      cnt_r       <= 4'd0;
      pend_v_r    <= 1'b0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    now_r       <= now_nxt;
    delay_r     <= delay_nxt;
    hdl_r       <= hdl_nxt;
    pend_hdl_r  <= pend_hdl_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_kind_r  <= out_kind_nxt;
    out_hdl_r   <= out_hdl_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.fired_handle = out_hdl_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.last         = out_last_r;

  `OSTT_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= ostt_pkg::MAX_OUT,
    "fire count exceeds result limit")
  `OSTT_ASSERT_NXT(a_fire_frees, clk, rst_n,
    state_r == ostt_pkg::S_CHK && fire && !(pend_v_r && !out_free),
    !busy_r[$past(idx_r)], "fired slot still busy")
  `OSTT_ASSERT_IMP(a_idle_no_pend, clk, rst_n, state_r == ostt_pkg::S_IDLE,
    !pend_v_r, "pending expiry left after poll")
  `OSTT_ASSERT_NXT(a_add_sets_busy, clk, rst_n,
    state_r == ostt_pkg::S_WRITE && out_free && free_found && !act_r,
    busy_r[$past(free_idx)], "added slot not marked busy")

endmodule

`default_nettype wire

// ===== tb/tb_one_shot_timer_table.sv =====
// ----------------------------------------------------------------------------
// tb_one_shot_timer_table
// self-checking bench for the one-shot timer table
// ----------------------------------------------------------------------------
// Add and poll transactions go in through a driver fed from a queue. A
// predictor keeps its own copy of the busy bits, deadlines and handles and
// works out the results of every accepted transaction. A monitor compares each
// result field by field with the oldest prediction. A directed part covers
// empty polls, deadlines equal to now, wrap-around, the half-range boundary,
// a full table and a poll that frees all slots. Random timelines of adds and
// polls with some noise follow. Both sides pause at random.
`default_nettype none

module tb_one_shot_timer_table;

  localparam int SLOTS        = 8;
  localparam int RAND_ITEMS   = 103;
  localparam int DRAIN_CYCLES = 3 * SLOTS + 20;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] now;
    logic [31:0] delay_usec;
    logic [7:0]  handle;
  } timer_req_t;

  typedef struct packed {
    ostt_pkg::kind_t kind;
    logic [7:0]      handle;
    logic [2:0]      slot;
    logic            last;
  } timer_event_t;

  logic clk;
  logic rst_n;

  ostt_in_if  in_ch ();
  ostt_out_if out_ch ();

  one_shot_timer_table #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  timer_req_t   pending_reqs[$];
  timer_event_t due_events[$];

  logic         tt_busy[SLOTS];
  logic [31:0]  tt_deadline[SLOTS];
  logic [7:0]   tt_handle[SLOTS];

  timer_req_t cur_req;
  int items_total;
  int items_done;
  int errors;
  int cycles;
  int send_pause;
  int burst_left;
  int stall_left;
  int calm_left;
  int n_adds, n_polls, n_added, n_full, n_expired, n_none;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_req(logic action, logic [31:0] now,
                                    logic [31:0] delay_usec, logic [7:0] handle);
    timer_req_t r;
    r.action     = action;
    r.now        = now;
    r.delay_usec = delay_usec;
    r.handle     = handle;
    pending_reqs.push_back(r);
  endfunction

  // updates the table copy and queues the results of one transaction
  function automatic void compute_timer_events(timer_req_t r);
    timer_event_t evs[$];
    logic [31:0]  diff;
    bit           placed;
    int           n;
    placed = 0;
    n = 0;
    if (r.action == ACT_ADD) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !tt_busy[i]) begin
          tt_busy[i]     = 1'b1;
          tt_deadline[i] = r.now + r.delay_usec / 32'd10;
          tt_handle[i]   = r.handle;
          due_events.push_back('{ostt_pkg::KIND_ADDED, 8'd0, 3'(i), 1'b1});
          placed = 1;
        end
      end
      if (!placed) due_events.push_back('{ostt_pkg::KIND_FULL, 8'd0, 3'd0, 1'b1});
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        diff = r.now - tt_deadline[i];
        if (tt_busy[i] && n < int'(ostt_pkg::MAX_OUT) && diff != 32'd0 && !diff[31]) begin
          tt_busy[i] = 1'b0;
          evs.push_back('{ostt_pkg::KIND_EXPIRED, tt_handle[i], 3'(i), 1'b0});
          n++;
        end
      end
      if (n == 0) begin
        due_events.push_back('{ostt_pkg::KIND_NONE, 8'd0, 3'd0, 1'b1});
      end else begin
        evs[n - 1].last = 1'b1;
        foreach (evs[k]) due_events.push_back(evs[k]);
      end
    end
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0d] mismatch: %s", cycles, what);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_pause = 0;
      burst_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        compute_timer_events(cur_req);
        items_done++;
        if (cur_req.action == ACT_ADD) n_adds++;
        else n_polls++;
        if (burst_left == 0 && $urandom_range(0, 11) == 0) burst_left = $urandom_range(4, 16);
        if (burst_left > 0) begin
          burst_left--;
          send_pause = 0;
        end else begin
          send_pause = pick_pause();
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_pause == 0 && pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.action     <= cur_req.action;
          in_ch.now        <= cur_req.now;
          in_ch.delay_usec <= cur_req.delay_usec;
          in_ch.handle     <= cur_req.handle;
        end else begin
          in_ch.valid <= 1'b0;
          if (send_pause > 0) send_pause--;
        end
      end
    end
  end

  // monitor and result sink
  always @(posedge clk) begin
    timer_event_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      calm_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        case (out_ch.kind)
          ostt_pkg::KIND_ADDED:   n_added++;
          ostt_pkg::KIND_FULL:    n_full++;
          ostt_pkg::KIND_EXPIRED: n_expired++;
          default:                n_none++;
        endcase
        if (due_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d handle %0d slot %0d last %0d",
                                    out_ch.kind, out_ch.fired_handle, out_ch.slot,
                                    out_ch.last));
        end else begin
          e = due_events.pop_front();
          if (out_ch.kind !== e.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_ch.kind, e.kind));
          if (out_ch.fired_handle !== e.handle)
            report_mismatch($sformatf("fired_handle %0d, expected %0d",
                                      out_ch.fired_handle, e.handle));
          if (out_ch.slot !== e.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", out_ch.slot, e.slot));
          if (out_ch.last !== e.last)
            report_mismatch($sformatf("last %0d, expected %0d", out_ch.last, e.last));
        end
      end
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 149) == 0) calm_left = $urandom_range(30, 150);
      if (stall_left == 0 && calm_left == 0 && $urandom_range(0, 99) < 20)
        stall_left = pick_pause();
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d transactions accepted",
               cycles, items_done, items_total);
      $display("tb_one_shot_timer_table NOT OK");
      $finish;
    end
  end

  initial begin
    logic [31:0] tick;
    int          r;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_ADD;
    in_ch.now        = 32'd0;
    in_ch.delay_usec = 32'd0;
    in_ch.handle     = 8'd0;
    out_ch.ready     = 1'b0;
    items_done = 0;
    errors = 0;
    cycles = 0;
    n_adds = 0;
    n_polls = 0;
    n_added = 0;
    n_full = 0;
    n_expired = 0;
    n_none = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tt_busy[i]     = 1'b0;
      tt_deadline[i] = 32'd0;
      tt_handle[i]   = 8'd0;
    end

    // empty table, zero handle, deadline equal to now
    queue_req(ACT_POLL, 32'd0, 32'd0, 8'd0);
    queue_req(ACT_ADD, 32'd100, 32'd0, 8'h00);
    queue_req(ACT_POLL, 32'd100, 32'd0, 8'd0);
    queue_req(ACT_POLL, 32'd101, 32'd0, 8'd0);
    // field extremes and deadlines that wrap
    queue_req(ACT_ADD, 32'hFFFF_FFF0, 32'd9, 8'hFF);
    queue_req(ACT_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'h5A);
    queue_req(ACT_ADD, 32'hFFFF_FFFA, 32'd100, 8'hA5);
    queue_req(ACT_ADD, 32'h0000_0010, 32'd10, 8'h01);
    queue_req(ACT_ADD, 32'h0000_0010, 32'd19, 8'h02);
    queue_req(ACT_ADD, 32'h8000_0000, 32'd20, 8'h03);
    queue_req(ACT_ADD, 32'h1234_5678, 32'h8000_0000, 8'h04);
    queue_req(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFF6, 8'h80);
    // table full
    queue_req(ACT_ADD, 32'hDEAD_BEEF, 32'd55, 8'h77);
    // across the wrap, then exactly half the range apart, then one less
    queue_req(ACT_POLL, 32'h0000_0005, 32'hFFFF_FFFF, 8'hFF);
    queue_req(ACT_POLL, 32'h8000_0011, 32'd0, 8'd0);
    queue_req(ACT_POLL, 32'h8000_0010, 32'd0, 8'd0);
    queue_req(ACT_POLL, 32'hFFFF_FFFF, 32'd0, 8'd0);
    queue_req(ACT_POLL, 32'h4000_0000, 32'd0, 8'd0);
    // fill every slot, then one poll frees them all
    for (int k = 0; k < SLOTS; k++) queue_req(ACT_ADD, 32'd0, 32'(k * 10), 8'(k * 37 + 3));
    queue_req(ACT_POLL, 32'd1000, 32'd0, 8'd0);

    tick = $urandom();
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if ($urandom_range(0, 19) == 0) tick = $urandom();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_req(1'($urandom_range(0, 1)), $urandom(), $urandom(), 8'($urandom_range(0, 255)));
      end else begin
        tick = tick + 32'($urandom_range(0, 12));
        if (r < 55)
          queue_req(ACT_ADD, tick,
                    ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 400)),
                    8'($urandom_range(0, 255)));
        else
          queue_req(ACT_POLL, tick, $urandom(), 8'($urandom_range(0, 255)));
      end
    end
    items_total = pending_reqs.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (items_done < items_total) @(posedge clk);
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (due_events.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_events.size()));
    $display("sent %0d adds and %0d polls in %0d cycles", n_adds, n_polls, cycles);
    $display("seen %0d added, %0d table full, %0d expired, %0d none; %0d mismatches",
             n_added, n_full, n_expired, n_none, errors);
    if (errors == 0) begin
      $display("tb_one_shot_timer_table OK");
    end else begin
      $display("tb_one_shot_timer_table NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== one_shot_timer_table.f =====
+incdir+hdl
hdl/ostt_pkg.sv
hdl/ostt_in_if.sv
hdl/ostt_out_if.sv
hdl/ostt_alu.sv
hdl/ostt_slot_mem.sv
hdl/one_shot_timer_table.sv
tb/tb_one_shot_timer_table.sv
